/* src/pie_pkg.sv */
// pie_pkg: types and constants of the png idat payload extractor
// used by pie_stream_if users and the top level; no dependencies
`timescale 1ns / 1ps

package pie_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [WordW-1:0] TYPE_IDAT = 32'h4944_4154;

  // length and type and crc fields around every payload
  localparam logic [WordW-1:0] CHUNK_OVERHEAD = 32'd12;
  localparam logic [WordW-1:0] SIG_LAST_POS   = 32'd7;
  localparam logic [WordW-1:0] IHDR_MIN_LEN   = 32'd10;
  localparam logic [WordW-1:0] IHDR_DEPTH_OFS = 32'd8;
  localparam logic [WordW-1:0] IHDR_COLOR_OFS = 32'd9;
  localparam logic [ByteW-1:0] DEPTH_EIGHT    = 8'd8;
  localparam logic [ByteW-1:0] COLOR_RGBA     = 8'd6;

  typedef enum logic [1:0] {
    FIELD_B0 = 2'd0,
    FIELD_B1 = 2'd1,
    FIELD_B2 = 2'd2,
    FIELD_B3 = 2'd3
  } field_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BAD_HEADER = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_PAY  = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_HALT = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
    logic             end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic             stream_done;
    status_e          status;
  } out_item_t;

endpackage

/* src/pie_stream_if.sv */
// pie_stream_if: valid/ready channel carrying one payload item per transfer
// payload type is a parameter, normally a struct from pie_pkg
`timescale 1ns / 1ps

interface pie_stream_if #(
  parameter type payload_t = logic [7:0]
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* src/png_idat_payload_extractor.sv */
// png_idat_payload_extractor: byte-serial png chunk walker passing out idat payload
// depends on pie_pkg and pie_stream_if
`timescale 1ns / 1ps

// One stream byte is taken per clock cycle and its result, if any, appears in the
// output register on the next cycle. All the work per byte, among it the
// position counter update, the chunk length limit compare and the payload counter
// compare, is done in one pass between the channel and the output register. The
// input stalls only while a result sits in the output register and the sink does
// not take it. A result is made for each idat payload byte, for the byte on which
// an error is found and for the byte flagged as end of stream; other bytes are
// consumed silently. Write stream_length before the first byte.
module png_idat_payload_extractor (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pie_pkg::WordW-1:0] cfg_wdata_i,
  pie_stream_if.sink               in_i,
  pie_stream_if.source             out_o
);

  import pie_pkg::*;

  logic [WordW-1:0] stream_len_q;
  phase_e           phase_q, phase_d;
  field_idx_e       idx_q, idx_d;
  logic [WordW-1:0] pos_q, pos_d;
  logic [WordW-1:0] len_q, len_d;
  logic [WordW-1:0] type_q, type_d;
  logic [WordW-1:0] cnt_q, cnt_d;
  status_e          err_q, err_d;
  logic [WordW-1:0] limit_q, limit_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  in_item_t         item;
  logic             in_fire;
  logic             emit;
  logic             new_err;
  logic [WordW-1:0] len_new;
  logic [WordW-1:0] type_new;
  logic [WordW-1:0] cnt_new;

  assign item     = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= '0;
    end else if (cfg_we_i) begin
      stream_len_q <= cfg_wdata_i;
    end
  end

  assign len_new  = {((idx_q == FIELD_B0) ? 24'd0 : len_q[WordW-ByteW-1:0]), item.stream_byte};
  assign type_new = {type_q[WordW-ByteW-1:0], item.stream_byte};
  assign cnt_new  = cnt_q + 32'd1;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    len_d   = len_q;
    type_d  = type_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    limit_d = limit_q;
    emit    = 1'b0;
    new_err = 1'b0;
    pos_d   = (pos_q == '1) ? pos_q : pos_q + 32'd1;

    case (phase_q)
      PH_SIG: begin
        if (pos_q >= SIG_LAST_POS) begin
          phase_d = PH_LEN;
          idx_d   = FIELD_B0;
        end
      end
      PH_LEN: begin
        if (idx_q == FIELD_B0 &&
            ({1'b0, pos_q} + {1'b0, CHUNK_OVERHEAD}) > {1'b0, stream_len_q}) begin
          // too few bytes left for another chunk: ignore the rest
          phase_d = PH_HALT;
        end else begin
          len_d = len_new;
          if (idx_q == FIELD_B0) begin
            // room left for the payload once this chunk's fields are counted
            limit_d = stream_len_q - pos_q - CHUNK_OVERHEAD;
          end
          if (idx_q == FIELD_B3) begin
            idx_d = FIELD_B0;
            if (len_new > limit_q) begin
              err_d   = STATUS_BAD_LENGTH;
              phase_d = PH_HALT;
              new_err = 1'b1;
            end else begin
              phase_d = PH_TYPE;
            end
          end else begin
            idx_d = field_idx_e'(idx_q + 2'd1);
          end
        end
      end
      PH_TYPE: begin
        type_d = type_new;
        if (idx_q == FIELD_B3) begin
          idx_d = FIELD_B0;
          cnt_d = '0;
          if (type_new == TYPE_IHDR && len_q < IHDR_MIN_LEN) begin
            err_d   = STATUS_BAD_HEADER;
            phase_d = PH_HALT;
            new_err = 1'b1;
          end else if (len_q == '0) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_PAY;
          end
        end else begin
          idx_d = field_idx_e'(idx_q + 2'd1);
        end
      end
      PH_PAY: begin
        emit = (type_q == TYPE_IDAT);
        if (type_q == TYPE_IHDR &&
            ((cnt_q == IHDR_DEPTH_OFS && item.stream_byte != DEPTH_EIGHT) ||
             (cnt_q == IHDR_COLOR_OFS && item.stream_byte != COLOR_RGBA))) begin
          err_d   = STATUS_BAD_HEADER;
          phase_d = PH_HALT;
          new_err = 1'b1;
        end else begin
          cnt_d = cnt_new;
          if (cnt_new >= len_q) begin
            phase_d = PH_CRC;
            idx_d   = FIELD_B0;
          end
        end
      end
      PH_CRC: begin
        if (idx_q == FIELD_B3) begin
          idx_d   = FIELD_B0;
          phase_d = PH_LEN;
        end else begin
          idx_d = field_idx_e'(idx_q + 2'd1);
        end
      end
      default: begin
      end
    endcase

    out_d.payload_valid = emit;
    out_d.payload_byte  = emit ? item.stream_byte : '0;
    out_d.stream_done   = item.end_of_stream;
    out_d.status        = err_d;

    // end of stream puts the parser back to its reset state
    if (item.end_of_stream) begin
      phase_d = PH_SIG;
      idx_d   = FIELD_B0;
      pos_d   = '0;
      len_d   = '0;
      type_d  = '0;
      cnt_d   = '0;
      err_d   = STATUS_OK;
    end

    if (in_fire) begin
      out_valid_d = emit || new_err || item.end_of_stream;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIG;
      idx_q       <= FIELD_B0;
      pos_q       <= '0;
      len_q       <= '0;
      type_q      <= '0;
      cnt_q       <= '0;
      err_q       <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        type_q  <= type_d;
        cnt_q   <= cnt_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      limit_q <= limit_d;
      out_q   <= out_d;
    end
  end

  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && item.end_of_stream |=> out_valid_q && out_q.stream_done)
    else $error("end of stream transfer gave no done result");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && item.end_of_stream |=> phase_q == PH_SIG && pos_q == '0 && err_q == STATUS_OK)
    else $error("parser not cleared after end of stream");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != STATUS_OK |-> phase_q == PH_HALT)
    else $error("error flagged while parsing continues");

  a_payload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.payload_valid |-> out_q.status == STATUS_OK)
    else $error("payload byte passed out after an error");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q) && $stable(pos_q))
    else $error("result or parser state changed during output stall");

endmodule
